FILE: design/fatan2_pkg.sv
// Shared types and constants for the fast_atan2_degrees pipeline.
// Holds the degree-scaled Q16 arctangent coefficients and the product rounding helper.
// No dependencies.
`default_nettype none

package fatan2_pkg;

    localparam int RATIO_W = 16;                   // Q0.16 ratio width
    localparam int QUO_W   = RATIO_W + 1;          // raw quotient, one guard bit
    localparam int COEF_W  = 22;                   // widest Horner partial value
    localparam int ANG_W   = 25;                   // Q16 angle up to 360 degrees

    localparam logic [RATIO_W:0] HALF16 = 17'd32768;

    // Odd 7th-order arctangent coefficients in degrees, Q16 magnitudes.
    localparam logic [COEF_W-1:0] COEF_P1 = 22'd3754140;
    localparam logic [COEF_W-1:0] COEF_P3 = 22'd1223390;
    localparam logic [COEF_W-1:0] COEF_P5 = 22'd584188;
    localparam logic [COEF_W-1:0] COEF_P7 = 22'd166449;

    localparam logic [ANG_W-1:0] DEG90_Q16  = 25'd5898240;
    localparam logic [ANG_W-1:0] DEG180_Q16 = 25'd11796480;
    localparam logic [ANG_W-1:0] DEG360_Q16 = 25'd23592960;

    typedef struct packed {
        logic zero;    // both inputs zero
        logic swap;    // |y| > |x|, reflect about 90 degrees
        logic neg_x;
        logic neg_y;
    } oct_flags_t;

    // Q16 product rounded half up back to Q16.
    function automatic logic [COEF_W-1:0] mul_q16(input logic [COEF_W-1:0] a,
                                                  input logic [RATIO_W-1:0] b);
        logic [COEF_W+RATIO_W:0] p;
        p = ({{(RATIO_W+1){1'b0}}, a} * {{(COEF_W+1){1'b0}}, b})
            + {{(COEF_W){1'b0}}, HALF16};
        return p[COEF_W+RATIO_W-1:RATIO_W];
    endfunction

endpackage

`default_nettype wire

FILE: design/fast_atan2_degrees.sv
// Top level of the gradient-direction unit: atan2(dy, dx) in degrees, Q9.F output.
// Depends on fatan2_pkg for coefficients, angle constants and the Q16 product helper.
`default_nettype none

//  channel   ports                          direction  meaning
//  -------   -----------------------------  ---------  -------------------------------
//  input     s_valid s_ready s_grad_y/x     in         signed gradient pair, IN_WIDTH
//  result    m_valid m_ready m_angle_deg    out        angle, 0..360 deg, F frac bits
//
//  From an input transfer to m_valid a pair passes 1 magnitude stage, 1 sort and
//  numerator stage, 17 restoring divider stages (one quotient bit each), 5 stages
//  for the Horner chain (one multiplier each), and 2 octant reflection and rounding
//  stages. One pair is taken every cycle while the result side takes results.
//  The whole pipeline advances on one enable; it holds when the last stage is full
//  and m_ready is low, and bubbles inside still advance behind an empty last stage.
//  Reset (aresetn low, synchronous) clears only the valid bits.

module fast_atan2_degrees #(
    parameter int IN_WIDTH        = 16,
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_valid,
    output logic                           s_ready,
    input  wire  [IN_WIDTH-1:0]            s_grad_y,
    input  wire  [IN_WIDTH-1:0]            s_grad_x,
    output logic                           m_valid,
    input  wire                            m_ready,
    output logic [9+ANGLE_FRAC_BITS-1:0]   m_angle_deg
);

    localparam int W       = IN_WIDTH;
    localparam int OUT_W   = 9 + ANGLE_FRAC_BITS;
    localparam int SH      = 16 - ANGLE_FRAC_BITS;
    localparam int DIV_N   = fatan2_pkg::QUO_W;
    localparam int NSTAGE  = 2 + DIV_N + 7;
    localparam int CW      = fatan2_pkg::COEF_W;
    localparam int RW      = fatan2_pkg::RATIO_W;
    localparam int AW      = fatan2_pkg::ANG_W;

    localparam logic [AW:0] RND_HALF = (AW+1)'(1) << (SH - 1);

    // Valid bits and the shared enable.
    logic [NSTAGE-1:0] vld_reg, vld_next;
    logic              adv;

    assign adv     = !vld_reg[NSTAGE-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[NSTAGE-1];

    always_comb begin
        vld_next = {vld_reg[NSTAGE-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    // Stage A: magnitudes and signs.
    logic [W-1:0] ay_reg, ay_next, ax_reg, ax_next;
    logic         ny_reg, ny_next, nx_reg, nx_next;

    always_comb begin
        ny_next = s_grad_y[W-1];
        nx_next = s_grad_x[W-1];
        ay_next = ny_next ? (~s_grad_y + W'(1)) : s_grad_y;
        ax_next = nx_next ? (~s_grad_x + W'(1)) : s_grad_x;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ay_reg <= ay_next;
            ax_reg <= ax_next;
            ny_reg <= ny_next;
            nx_reg <= nx_next;
        end
    end

    // Stage B: sort into lo/hi, build the rounded numerator, seed the divider.
    // Divider arrays: index 0 is stage B, index k+1 is after quotient step k.
    logic [W-1:0]                  rem_reg [0:DIV_N];
    logic [W-1:0]                  hi_reg  [0:DIV_N];
    logic [DIV_N-1:0]              nlo_reg [0:DIV_N];
    logic [DIV_N-1:0]              quo_reg [0:DIV_N];
    fatan2_pkg::oct_flags_t        flg_reg [0:DIV_N];

    logic [W-1:0]           lo_b, hi_b;
    logic [W+15:0]          num_b;
    fatan2_pkg::oct_flags_t flg_next;
    logic [W-1:0]           rem0_next;
    logic [DIV_N-1:0]       nlo0_next;

    always_comb begin
        flg_next.swap  = (ax_reg < ay_reg);
        lo_b           = flg_next.swap ? ax_reg : ay_reg;
        hi_b           = flg_next.swap ? ay_reg : ax_reg;
        flg_next.zero  = (hi_b == '0);
        flg_next.neg_x = nx_reg;
        flg_next.neg_y = ny_reg;
        num_b          = {lo_b, 16'b0} + {17'b0, hi_b[W-1:1]};
        rem0_next      = {1'b0, num_b[W+15:DIV_N]};
        nlo0_next      = num_b[DIV_N-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg[0] <= rem0_next;
            hi_reg[0]  <= hi_b;
            nlo_reg[0] <= nlo0_next;
            quo_reg[0] <= '0;
            flg_reg[0] <= flg_next;
        end
    end

    // Restoring divider: one quotient bit per stage, MSB first.
    for (genvar k = 0; k < DIV_N; k++) begin : g_div
        logic [W:0]       trial;
        logic [W:0]       diff;
        logic             ge;
        logic [W-1:0]     rem_next;
        logic [DIV_N-1:0] quo_next;

        always_comb begin
            trial    = {rem_reg[k], nlo_reg[k][DIV_N-1]};
            diff     = trial - {1'b0, hi_reg[k]};
            ge       = (trial >= {1'b0, hi_reg[k]});
            rem_next = ge ? diff[W-1:0] : trial[W-1:0];
            quo_next = {quo_reg[k][DIV_N-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k+1] <= rem_next;
                hi_reg[k+1]  <= hi_reg[k];
                nlo_reg[k+1] <= {nlo_reg[k][DIV_N-2:0], 1'b0};
                quo_reg[k+1] <= quo_next;
                flg_reg[k+1] <= flg_reg[k];
            end
        end
    end

    // Stage C: saturate the ratio, square it.
    logic [RW-1:0]          c_c_reg, c_c_next, c2_c_reg, c2_c_next;
    fatan2_pkg::oct_flags_t flg_c_reg;
    logic [CW-1:0]          sq_c;

    always_comb begin
        if (flg_reg[DIV_N].zero) begin
            c_c_next = '0;
        end else if (quo_reg[DIV_N][DIV_N-1]) begin
            c_c_next = '1;
        end else begin
            c_c_next = quo_reg[DIV_N][RW-1:0];
        end
        sq_c      = fatan2_pkg::mul_q16({{(CW-RW){1'b0}}, c_c_next}, c_c_next);
        c2_c_next = sq_c[RW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_c_reg   <= c_c_next;
            c2_c_reg  <= c2_c_next;
            flg_c_reg <= flg_reg[DIV_N];
        end
    end

    // Stages D, E, F: Horner steps on magnitudes; G: final multiply by the ratio.
    logic [CW-1:0]          u_reg, u_next, v_reg, v_next, w_reg, w_next, a_reg, a_next;
    logic [RW-1:0]          c_d_reg, c_e_reg, c_f_reg;
    logic [RW-1:0]          c2_d_reg, c2_e_reg;
    fatan2_pkg::oct_flags_t flg_d_reg, flg_e_reg, flg_f_reg, flg_g_reg;

    always_comb begin
        u_next = fatan2_pkg::COEF_P5 - fatan2_pkg::mul_q16(fatan2_pkg::COEF_P7, c2_c_reg);
        v_next = fatan2_pkg::COEF_P3 - fatan2_pkg::mul_q16(u_reg, c2_d_reg);
        w_next = fatan2_pkg::COEF_P1 - fatan2_pkg::mul_q16(v_reg, c2_e_reg);
        a_next = fatan2_pkg::mul_q16(w_reg, c_f_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            u_reg     <= u_next;
            c_d_reg   <= c_c_reg;
            c2_d_reg  <= c2_c_reg;
            flg_d_reg <= flg_c_reg;

            v_reg     <= v_next;
            c_e_reg   <= c_d_reg;
            c2_e_reg  <= c2_d_reg;
            flg_e_reg <= flg_d_reg;

            w_reg     <= w_next;
            c_f_reg   <= c_e_reg;
            flg_f_reg <= flg_e_reg;

            a_reg     <= a_next;
            flg_g_reg <= flg_f_reg;
        end
    end

    // Stage H: reflect about 90, then about 180.
    logic [AW-1:0] a1_h, ang_h_reg, ang_h_next;
    logic          ny_h_reg;

    always_comb begin
        a1_h       = flg_g_reg.swap ? (fatan2_pkg::DEG90_Q16 - AW'(a_reg)) : AW'(a_reg);
        ang_h_next = flg_g_reg.neg_x ? (fatan2_pkg::DEG180_Q16 - a1_h) : a1_h;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ang_h_reg <= ang_h_next;
            ny_h_reg  <= flg_g_reg.neg_y;
        end
    end

    // Stage I: reflect about 360, round half up to the output fraction bits.
    logic [AW-1:0]    a3_i;
    logic [AW:0]      rnd_i;
    logic [OUT_W-1:0] res_reg, res_next;

    always_comb begin
        a3_i     = ny_h_reg ? (fatan2_pkg::DEG360_Q16 - ang_h_reg) : ang_h_reg;
        rnd_i    = {1'b0, a3_i} + RND_HALF;
        res_next = rnd_i[SH+OUT_W-1:SH];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            res_reg <= res_next;
        end
    end

    assign m_angle_deg = res_reg;

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking bench for fast_atan2_degrees: drives gradient pairs, predicts the angle.
// The prediction is bit exact: Q0.16 ratio, then the Q16 degree polynomial, then the octant fold.
// Depends only on the design top level and its package.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W        = 16;
    localparam int FRAC_W      = 6;
    localparam int OUT_W       = 9 + FRAC_W;
    localparam int PAIR_COUNT  = 1700;
    localparam int HOLD_CYCLES = 400;     // long result stall, fills the pipeline
    localparam int DRAIN_WAIT  = 40;      // idle wait once no angle is owed, to catch strays
    localparam int STALL_LIMIT = 5000;    // cycles without any transfer

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [IN_W-1:0]     s_grad_y;
    logic [IN_W-1:0]     s_grad_x;
    logic                m_valid;
    logic                m_ready;
    logic [OUT_W-1:0]    m_angle_deg;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          hold_request;
    int unsigned hold_left;
    int unsigned quiet_cycles;

    fast_atan2_degrees #(
        .IN_WIDTH        (IN_W),
        .ANGLE_FRAC_BITS (FRAC_W)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_grad_y    (s_grad_y),
        .s_grad_x    (s_grad_x),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_angle_deg (m_angle_deg)
    );

    // Holds the angles still owed by the block, in transfer order, and checks each
    // result against the oldest one.
    class direction_scoreboard;
        logic [OUT_W-1:0] angle_q[$];
        int unsigned      pairs_in;
        int unsigned      angles_out;
        int unsigned      full_turns;
        int unsigned      mismatches;

        // Q16 product rounded half up back to Q16.
        function longint unsigned round_mul(longint unsigned a, longint unsigned b);
            return (a * b + 64'd32768) >> 16;
        endfunction

        // Work out the angle for one accepted pair and queue it.
        function void note_pair(logic [IN_W-1:0] gy, logic [IN_W-1:0] gx);
            logic [IN_W-1:0] my;
            logic [IN_W-1:0] mx;
            longint unsigned ay, ax, lo, hi, ratio, c2, u, v, w, ang, res;
            my = gy[IN_W-1] ? -gy : gy;
            mx = gx[IN_W-1] ? -gx : gx;
            ay = my;
            ax = mx;
            lo = (ax >= ay) ? ay : ax;
            hi = (ax >= ay) ? ax : ay;
            // Both inputs zero: ratio stays 0. Equal magnitudes saturate just below 1.0.
            ratio = 0;
            if (hi != 0) begin
                ratio = ((lo << 16) + (hi >> 1)) / hi;
                if (ratio > 65535)
                    ratio = 65535;
            end
            // Horner on magnitudes: p1 - c2*(p3 - c2*(p5 - c2*p7)), then times c.
            c2  = round_mul(ratio, ratio);
            u   = 64'd584188  - round_mul(64'd166449, c2);
            v   = 64'd1223390 - round_mul(u, c2);
            w   = 64'd3754140 - round_mul(v, c2);
            ang = round_mul(w, ratio);
            // Fold into the octant: steep, then left half, then lower half.
            if (ax < ay)
                ang = 64'd5898240 - ang;
            if (gx[IN_W-1])
                ang = 64'd11796480 - ang;
            if (gy[IN_W-1])
                ang = 64'd23592960 - ang;
            res = (ang + (64'd1 << (16 - FRAC_W - 1))) >> (16 - FRAC_W);
            angle_q.push_back(res[OUT_W-1:0]);
            pairs_in++;
        endfunction

        function void check_angle(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (angle_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("angle %0d arrived with no pair outstanding", got);
                return;
            end
            want = angle_q.pop_front();
            angles_out++;
            if (got === want) begin
                if (got == OUT_W'(360 << FRAC_W))
                    full_turns++;
            end else begin
                mismatches++;
                if (mismatches <= 10)
                    $display("angle #%0d mismatch: expected %0d, got %0d",
                             angles_out, want, got);
            end
        endfunction
    endclass

    direction_scoreboard sb = new();

    always #5 aclk = ~aclk;

    // Record transfers on both channels from pre-edge values.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_pair(s_grad_y, s_grad_x);
        if (aresetn && m_valid && m_ready)
            sb.check_angle(m_angle_deg);
    end

    // Result side: random back-pressure, plus one long hold-off on request
    // while the sender keeps offering pairs.
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                m_ready     <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Watchdog: end the run when nothing has moved for too long.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Offer one pair, with random idle cycles ahead of it, and hold it until
    // the transfer completes.
    task automatic send_pair(input logic [IN_W-1:0] gy, input logic [IN_W-1:0] gx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_grad_y <= gy;
        s_grad_x <= gx;
        do @(posedge aclk); while (!s_ready);
    endtask

    initial begin
        int          kind;
        int          a;
        int          b;
        int unsigned n;
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_grad_y     = '0;
        s_grad_x     = '0;
        m_ready      = 1'b0;
        hold_request = 1'b0;
        hold_left    = 0;
        tx_idle_pct  = 9;
        rx_idle_pct  = 9;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corners: origin, the four axes, diagonals of every sign,
        // most negative magnitudes, tiny negative y that rounds to a full turn.
        send_pair(16'sd0,      16'sd0);
        send_pair(16'sd0,      16'sd1);
        send_pair(16'sd1,      16'sd0);
        send_pair(16'sd0,      -16'sd1);
        send_pair(-16'sd1,     16'sd0);
        send_pair(16'sd32767,  16'sd32767);
        send_pair(-16'sd32768, -16'sd32768);
        send_pair(-16'sd32768, 16'sd32767);
        send_pair(16'sd32767,  -16'sd32768);
        send_pair(-16'sd32768, 16'sd0);
        send_pair(16'sd0,      -16'sd32768);
        send_pair(16'sd1,      16'sd1);
        send_pair(-16'sd1,     -16'sd1);
        send_pair(16'sd1,      -16'sd1);
        send_pair(-16'sd1,     16'sd1);
        send_pair(16'sd5,      -16'sd5);
        send_pair(-16'sd1,     16'sd32767);
        send_pair(-16'sd1,     16'sd20000);
        send_pair(16'sd100,    -16'sd32768);
        send_pair(16'sd32767,  16'sd1);
        send_pair(16'sd1,      16'sd32767);
        send_pair(-16'sd32768, 16'sd1);

        for (n = 0; n < PAIR_COUNT; n++) begin
            // No idling at all through the middle stretch.
            if (n >= 900 && n < 1200) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 9;
                rx_idle_pct = 9;
            end
            if (n == 500)
                hold_request = 1'b1;

            kind = $urandom_range(9);
            case (kind)
                4: begin
                    a = int'($urandom_range(32)) - 16;
                    b = int'($urandom_range(32)) - 16;
                end
                5: begin
                    // equal magnitudes, random signs
                    a = int'($urandom_range(32768));
                    b = $urandom_range(1) ? -a : a;
                    a = $urandom_range(1) ? -a : a;
                end
                6: begin
                    a = int'($urandom);
                    b = 0;
                    if ($urandom_range(1)) begin
                        b = a;
                        a = 0;
                    end
                end
                7: begin
                    a = 32767 - int'($urandom_range(2));
                    b = -32768 + int'($urandom_range(2));
                    if ($urandom_range(1))
                        a = -a - 1;
                    if ($urandom_range(1))
                        b = -b - 1;
                end
                8: begin
                    // tiny negative y against a long x
                    a = -int'($urandom_range(3, 1));
                    b = int'($urandom_range(32767, 8000));
                    if ($urandom_range(1))
                        b = -b;
                end
                9: begin
                    // near the diagonal
                    a = int'($urandom_range(32000));
                    b = a + int'($urandom_range(8)) - 4;
                    if ($urandom_range(1))
                        a = -a;
                    if ($urandom_range(1))
                        b = -b;
                end
                default: begin
                    a = int'($urandom);
                    b = int'($urandom);
                end
            endcase
            send_pair(a[IN_W-1:0], b[IN_W-1:0]);
        end
        s_valid <= 1'b0;

        // Drain: wait for every owed angle, then watch for strays.
        while (sb.angle_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("Covered %0d gradient pairs (axes, diagonals, origin, extreme magnitudes)",
                 sb.pairs_in);
        $display("and %0d angles, %0d of them a full turn, through one %0d-cycle result stall",
                 sb.angles_out, sb.full_turns, HOLD_CYCLES);
        if (sb.mismatches == 0 && sb.angle_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d angles missing", sb.mismatches, sb.angle_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
